/* rtl/att_pkg.sv */
`default_nettype none

package att_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int RESULT_LIMIT  = 16;

  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int RES_W   = 3;
  localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_CHANGE = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [RES_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_CHANGED   = 3'd1,
    RES_CANCELLED = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_FULL      = 3'd4,
    RES_EXPIRED   = 3'd5
  } res_t;

  // Action broadcast to every cell of the chain
  typedef enum logic [2:0] {
    ACT_HOLD    = 3'd0,
    ACT_START   = 3'd1,
    ACT_ADVANCE = 3'd2,
    ACT_INSERT  = 3'd3,
    ACT_CHANGE  = 3'd4,
    ACT_DELETE  = 3'd5
  } act_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    act_t              act;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now;
  } cell_cmd_t;

  // Compare results of one cell, with its scan token flag
  typedef struct packed {
    logic            tok;
    logic            valid;
    logic            match;
    logic            place;
    logic            due;
    logic [ID_W-1:0] ident;
  } cell_stat_t;

  // Status of the cell under the token, plus the full and token-present flags
  typedef struct packed {
    logic            tok_any;
    logic            full;
    logic            valid;
    logic            match;
    logic            place;
    logic            due;
    logic [ID_W-1:0] ident;
  } scan_stat_t;

endpackage

`default_nettype wire

/* rtl/att_cell.sv */
`default_nettype none

module att_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire att_pkg::cell_cmd_t cmd,
  input  wire att_pkg::entry_t    left_entry,
  input  wire logic               left_therm,
  input  wire att_pkg::entry_t    right_entry,
  output att_pkg::entry_t         entry,
  output logic                    therm,
  output att_pkg::cell_stat_t     stat
);
  import att_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   ident_r, ident_nxt;
  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic              therm_r, therm_nxt;
  logic              tok;

  // Token sits on the first cell of the thermometer run
  assign tok = therm_r & ~left_therm;

  assign entry = '{valid: valid_r, ident: ident_r, expiry: expiry_r};
  assign therm = therm_r;

  // Local compares against the broadcast command
  always_comb begin
    stat.tok   = tok;
    stat.valid = valid_r;
    stat.match = valid_r && (ident_r == cmd.id);
    stat.place = !valid_r || (ident_r > cmd.id) ||
                 ((ident_r == cmd.id) && (expiry_r >= cmd.expiry));
    stat.due   = valid_r && (expiry_r <= cmd.now);
    stat.ident = ident_r;
  end

  // Load from a neighbor, from the command, or hold
  always_comb begin
    valid_nxt  = valid_r;
    ident_nxt  = ident_r;
    expiry_nxt = expiry_r;
    therm_nxt  = therm_r;
    unique case (cmd.act)
      ACT_HOLD: begin
      end
      ACT_START: begin
        therm_nxt = 1'b1;
      end
      ACT_ADVANCE: begin
        therm_nxt = left_therm;
      end
      ACT_INSERT: begin
        if (tok) begin
          valid_nxt  = 1'b1;
          ident_nxt  = cmd.id;
          expiry_nxt = cmd.expiry;
        end else if (therm_r) begin
          valid_nxt  = left_entry.valid;
          ident_nxt  = left_entry.ident;
          expiry_nxt = left_entry.expiry;
        end
      end
      ACT_CHANGE: begin
        if (tok) begin
          expiry_nxt = cmd.expiry;
        end
      end
      ACT_DELETE: begin
        if (therm_r) begin
          valid_nxt  = right_entry.valid;
          ident_nxt  = right_entry.ident;
          expiry_nxt = right_entry.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      therm_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      therm_r <= therm_nxt;
    end
    ident_r  <= ident_nxt;
    expiry_r <= expiry_nxt;
  end

endmodule

`default_nettype wire

/* rtl/att_ctrl.sv */
`default_nettype none

module att_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [att_pkg::OP_W-1:0]     in_op,
  input  wire logic [att_pkg::ID_W-1:0]     in_alarm_id,
  input  wire logic [att_pkg::DELAY_W-1:0]  in_delay_seconds,
  input  wire att_pkg::scan_stat_t          scan,
  output att_pkg::cell_cmd_t                cmd,
  output logic                              out_valid,
  output logic [att_pkg::RES_W-1:0]         out_event_res,
  output logic [att_pkg::ID_W-1:0]          out_event_id,
  output logic [att_pkg::TIME_W-1:0]        out_event_time,
  output logic                              out_last
);
  import att_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  act_t              act;
  logic              done;
  logic              emit_one;
  res_t              emit_res;
  logic              emit_exp;
  logic              flush;
  logic [TIME_W:0]   exp_sum;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Expiry of a new or re-armed alarm, saturated
  assign exp_sum = {1'b0, now_r} + {{(TIME_W + 1 - DELAY_W){1'b0}}, in_delay_seconds};
  assign exp_nxt = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

  assign cmd = '{act: act, id: id_r, expiry: exp_r, now: now_r};

  // Decide the action for the cell under the token
  always_comb begin
    act      = ACT_HOLD;
    done     = 1'b0;
    emit_one = 1'b0;
    emit_res = RES_NOT_FOUND;
    emit_exp = 1'b0;
    flush    = 1'b0;
    if (state_r == ST_IDLE) begin
      if (accept) begin
        act = ACT_START;
      end
    end else begin
      case (op_r) inside
        OP_INSERT: begin
          if (scan.full || !scan.tok_any) begin
            done     = 1'b1;
            emit_one = 1'b1;
            emit_res = RES_FULL;
          end else if (scan.place) begin
            act      = ACT_INSERT;
            done     = 1'b1;
            emit_one = 1'b1;
            emit_res = RES_INSERTED;
          end else begin
            act = ACT_ADVANCE;
          end
        end
        OP_CHANGE, OP_CANCEL: begin
          if (!scan.tok_any || !scan.valid) begin
            done     = 1'b1;
            emit_one = 1'b1;
            emit_res = RES_NOT_FOUND;
          end else if (scan.match) begin
            done     = 1'b1;
            emit_one = 1'b1;
            if (op_r == OP_CHANGE) begin
              act      = ACT_CHANGE;
              emit_res = RES_CHANGED;
            end else begin
              act      = ACT_DELETE;
              emit_res = RES_CANCELLED;
            end
          end else begin
            act = ACT_ADVANCE;
          end
        end
        default: begin
          if (scan.tok_any && scan.valid && scan.due && (cnt_r < CNT_W'(RESULT_LIMIT))) begin
            act      = ACT_DELETE;
            emit_exp = 1'b1;
          end else if (scan.tok_any && scan.valid) begin
            act = ACT_ADVANCE;
          end else begin
            done  = 1'b1;
            flush = 1'b1;
          end
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Counter, pending expiry word and result word
  always_comb begin
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    if (accept) begin
      cnt_nxt        = '0;
      pend_valid_nxt = 1'b0;
      if (op_t'(in_op) == OP_TICK) begin
        now_nxt = now_r + TIME_W'(1);
      end
    end
    if (emit_one) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
      out_id_nxt    = id_r;
      out_time_nxt  = now_r;
      out_last_nxt  = 1'b1;
    end else if ((emit_exp || flush) && pend_valid_r) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = RES_EXPIRED;
      out_id_nxt    = pend_id_r;
      out_time_nxt  = now_r;
      out_last_nxt  = flush;
    end
    // Hold each expiry back one step so the final one carries last
    if (emit_exp) begin
      pend_valid_nxt = 1'b1;
      pend_id_nxt    = scan.ident;
      cnt_nxt        = cnt_r + CNT_W'(1);
    end else if (flush) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (accept) begin
      op_r  <= op_t'(in_op);
      id_r  <= in_alarm_id;
      exp_r <= exp_nxt;
    end
    pend_id_r  <= pend_id_nxt;
    out_res_r  <= out_res_nxt;
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_res_r;
  assign out_event_id   = out_id_r;
  assign out_event_time = out_time_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/alarm_timer_table.sv */
// Alarm timer table: up to TABLE_ENTRIES pending alarms kept in order of
// identifier, then expiry, in a chain of cells.
// Command channel: a word (in_op, in_alarm_id, in_delay_seconds) is taken
// at a clock edge with start high and busy low. Insert, change and cancel
// answer with one result word; a tick advances the seconds counter and
// answers with one expired word per due alarm in table order (none if
// nothing is due).
// Result channel: out_valid marks each result word for exactly one cycle;
// out_last flags the final word of a command. The receiver cannot stall.
// Timing: a scan token walks one cell per cycle while cells are passed,
// and stays put while the alarm under it is removed. Insert, change and
// cancel put out their result word when the scan ends; a tick puts out
// its final word when the token runs past the valid entries. busy stays
// high until the last result word is registered, so one command runs at
// a time and the next one can be taken in the cycle that word is on the
// outputs.
// Reset (rst_n low, synchronous) empties the table and clears the seconds
// counter; no clearing pass is needed.
`default_nettype none

module alarm_timer_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [att_pkg::OP_W-1:0]     in_op,
  input  wire logic [att_pkg::ID_W-1:0]     in_alarm_id,
  input  wire logic [att_pkg::DELAY_W-1:0]  in_delay_seconds,
  output logic                              out_valid,
  output logic [att_pkg::RES_W-1:0]         out_event_res,
  output logic [att_pkg::ID_W-1:0]          out_event_id,
  output logic [att_pkg::TIME_W-1:0]        out_event_time,
  output logic                              out_last
);
  import att_pkg::*;

  cell_cmd_t  cmd;
  scan_stat_t scan;
  entry_t     entries [TABLE_ENTRIES];
  logic       therms  [TABLE_ENTRIES];
  cell_stat_t stats   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES:0]   valid_inc;

  // Row of cells, each tied to its neighbors
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_t;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_t = 1'b0;
    end else begin : g_body
      assign left_e = entries[i-1];
      assign left_t = therms[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    att_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_e),
      .left_therm  (left_t),
      .right_entry (right_e),
      .entry       (entries[i]),
      .therm       (therms[i]),
      .stat        (stats[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  // Pick out the status of the cell under the token
  always_comb begin
    scan         = '0;
    scan.full    = entries[TABLE_ENTRIES-1].valid;
    scan.tok_any = therms[TABLE_ENTRIES-1];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (stats[i].tok) begin
        scan.valid = scan.valid | stats[i].valid;
        scan.match = scan.match | stats[i].match;
        scan.place = scan.place | stats[i].place;
        scan.due   = scan.due   | stats[i].due;
        scan.ident = scan.ident | stats[i].ident;
      end
    end
  end

  att_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_alarm_id      (in_alarm_id),
    .in_delay_seconds (in_delay_seconds),
    .scan             (scan),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_event_res    (out_event_res),
    .out_event_id     (out_event_id),
    .out_event_time   (out_event_time),
    .out_last         (out_last)
  );

  assign valid_inc = {1'b0, valid_vec} + (TABLE_ENTRIES + 1)'(1);

  // Valid entries always fill the head of the chain without gaps
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(valid_inc))
    else $error("valid entries not contiguous");

  // A result word only follows a cycle of work on a command
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a command in progress");

  // The final word of a command is not followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result word right after the final word");

  // An accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command accepted but block not busy");

endmodule

`default_nettype wire
